/* rtl/core/tahs_pkg.sv */
`default_nettype none
package tahs_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;
  localparam int unsigned TOL_W         = 31;
  localparam int unsigned REG_IDX_W     = 3;

  localparam logic [63:0] RST_TOL     = 64'd655;
  localparam logic [63:0] RST_COARSE  = 64'd65536;
  localparam logic [63:0] RST_FINE    = 64'd13107;
  localparam logic [63:0] RST_A_END   = 64'd0;
  localparam logic [63:0] RST_A_FAR   = 64'd196608;
  localparam logic [63:0] RST_B_END   = 64'd0;
  localparam logic [63:0] RST_B_START = 64'd98304;
  localparam logic [63:0] RST_BACKOFF = 64'd13107;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_COARSE  = 4'd1,
    PH_BACKOFF = 4'd2,
    PH_FINE    = 4'd3,
    PH_A_FAR   = 4'd4,
    PH_B_PLACE = 4'd5,
    PH_RISE    = 4'd6,
    PH_FALL    = 4'd7,
    PH_ZERO    = 4'd8,
    PH_DONE    = 4'd9
  } phase_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TOL      = 3'd0,
    REG_COARSE   = 3'd1,
    REG_FINE     = 3'd2,
    REG_A_END    = 3'd3,
    REG_A_FAR    = 3'd4,
    REG_B_END    = 3'd5,
    REG_B_START  = 3'd6,
    REG_BACKOFF  = 3'd7
  } reg_idx_e;

endpackage
`default_nettype wire

/* rtl/core/tahs_if.sv */
`default_nettype none
interface tahs_in_if #(
  parameter int unsigned POS_WIDTH = tahs_pkg::POS_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        start_req;
  logic                        endstop_a_level;
  logic                        endstop_b_level;
  logic signed [POS_WIDTH-1:0] pos_a;
  logic signed [POS_WIDTH-1:0] pos_b;

  modport source (
    output valid, start_req, endstop_a_level, endstop_b_level, pos_a, pos_b,
    input  ready
  );
  modport sink (
    input  valid, start_req, endstop_a_level, endstop_b_level, pos_a, pos_b,
    output ready
  );
endinterface

interface tahs_res_if #(
  parameter int unsigned POS_WIDTH = tahs_pkg::POS_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] vel_a_cmd;
  logic signed [POS_WIDTH-1:0] pos_a_target;
  logic signed [POS_WIDTH-1:0] vel_b_cmd;
  logic signed [POS_WIDTH-1:0] pos_b_target;
  logic                        load_enc_a;
  logic signed [POS_WIDTH-1:0] enc_a_value;
  logic                        load_enc_b;
  logic signed [POS_WIDTH-1:0] enc_b_value;
  logic [3:0]                  phase;
  logic                        done_res;

  modport source (
    output valid, vel_a_cmd, pos_a_target, vel_b_cmd, pos_b_target, load_enc_a,
           enc_a_value, load_enc_b, enc_b_value, phase, done_res,
    input  ready
  );
  modport sink (
    input  valid, vel_a_cmd, pos_a_target, vel_b_cmd, pos_b_target, load_enc_a,
           enc_a_value, load_enc_b, enc_b_value, phase, done_res,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/core/tahs_cfg_regs.sv */
`default_nettype none
module tahs_cfg_regs #(
  parameter int unsigned POS_WIDTH = tahs_pkg::POS_WIDTH_DEF,
  parameter type cfg_t = logic,
  localparam int unsigned DATA_W   = (POS_WIDTH > 32) ? 64 : 32,
  localparam int unsigned ADDR_LSB = (POS_WIDTH > 32) ? 3 : 2,
  localparam int unsigned ADDR_W   = ADDR_LSB + tahs_pkg::REG_IDX_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);
  import tahs_pkg::*;

  typedef logic signed [POS_WIDTH-1:0] pos_t;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;
  pos_t     wval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:ADDR_LSB]);
  assign wval   = pwdata[POS_WIDTH-1:0];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tol          <= RST_TOL[TOL_W-1:0];
      cfg_q.coarse_speed <= RST_COARSE[POS_WIDTH-1:0];
      cfg_q.fine_speed   <= RST_FINE[POS_WIDTH-1:0];
      cfg_q.a_end        <= RST_A_END[POS_WIDTH-1:0];
      cfg_q.a_far        <= RST_A_FAR[POS_WIDTH-1:0];
      cfg_q.b_end        <= RST_B_END[POS_WIDTH-1:0];
      cfg_q.b_start      <= RST_B_START[POS_WIDTH-1:0];
      cfg_q.backoff      <= RST_BACKOFF[TOL_W-1:0];
    end else if (wr_en) begin
      unique case (idx)
        REG_TOL:     cfg_q.tol          <= pwdata[TOL_W-1:0];
        REG_COARSE:  cfg_q.coarse_speed <= wval;
        REG_FINE:    cfg_q.fine_speed   <= wval;
        REG_A_END:   cfg_q.a_end        <= wval;
        REG_A_FAR:   cfg_q.a_far        <= wval;
        REG_B_END:   cfg_q.b_end        <= wval;
        REG_B_START: cfg_q.b_start      <= wval;
        REG_BACKOFF: cfg_q.backoff      <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_TOL:     prdata = DATA_W'(cfg_q.tol);
      REG_COARSE:  prdata = DATA_W'($signed(cfg_q.coarse_speed));
      REG_FINE:    prdata = DATA_W'($signed(cfg_q.fine_speed));
      REG_A_END:   prdata = DATA_W'($signed(cfg_q.a_end));
      REG_A_FAR:   prdata = DATA_W'($signed(cfg_q.a_far));
      REG_B_END:   prdata = DATA_W'($signed(cfg_q.b_end));
      REG_B_START: prdata = DATA_W'($signed(cfg_q.b_start));
      REG_BACKOFF: prdata = DATA_W'(cfg_q.backoff);
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/tahs_step.sv */
`default_nettype none
module tahs_step #(
  parameter int unsigned POS_WIDTH = tahs_pkg::POS_WIDTH_DEF,
  parameter type cfg_t   = logic,
  parameter type state_t = logic,
  parameter type item_t  = logic,
  parameter type res_t   = logic
) (
  input  wire cfg_t   cfg_i,
  input  wire state_t state_i,
  input  wire item_t  item_i,
  output state_t      state_o,
  output res_t        res_o
);
  import tahs_pkg::*;

  typedef logic signed [POS_WIDTH-1:0] pos_t;

  localparam int unsigned SW = ((POS_WIDTH > TOL_W) ? POS_WIDTH : TOL_W) + 2;
  localparam int unsigned CW = ((POS_WIDTH + 1) > TOL_W) ? (POS_WIDTH + 1) : TOL_W;
  localparam pos_t PMAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam pos_t PMIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  function automatic logic reached(input pos_t p, input pos_t t,
                                   input logic [TOL_W-1:0] tol);
    logic signed [POS_WIDTH:0] d;
    logic        [POS_WIDTH:0] m;
    d = (POS_WIDTH+1)'(p) - (POS_WIDTH+1)'(t);
    m = d[POS_WIDTH] ? $unsigned(-d) : $unsigned(d);
    return CW'(m) < CW'(tol);
  endfunction

  function automatic pos_t sat(input logic signed [SW-1:0] s);
    if (s > SW'(PMAX)) begin
      return PMAX;
    end else if (s < SW'(PMIN)) begin
      return PMIN;
    end
    return s[POS_WIDTH-1:0];
  endfunction

  logic                 sw_a, sw_b, hit_a, hit_b;
  pos_t                 pa, pb;
  logic signed [SW-1:0] back_sum, half_diff, cal_sum;
  pos_t                 back_tgt, neg_fine, cal_pos;
  phase_e               phase_d;
  state_t               state_d;
  logic                 lda, ldb;
  pos_t                 enca, encb;

  assign sw_a  = item_i.endstop_a_level;
  assign sw_b  = !item_i.endstop_b_level;
  assign pa    = item_i.pos_a;
  assign pb    = item_i.pos_b;
  assign hit_a = reached(pa, state_i.tgt_a, cfg_i.tol);
  assign hit_b = reached(pb, state_i.tgt_b, cfg_i.tol);

  always_comb begin
    back_sum  = SW'(pa) - $signed(SW'(cfg_i.backoff));
    back_tgt  = sat(back_sum);
    half_diff = SW'(pb) - SW'($signed(state_i.rise_pos));
    half_diff = half_diff >>> 1;
    cal_sum   = half_diff + SW'($signed(cfg_i.b_end));
    cal_pos   = sat(cal_sum);
    neg_fine  = (cfg_i.fine_speed == PMIN) ? PMAX : -cfg_i.fine_speed;
  end

  always_comb begin
    phase_d = phase_e'(state_i.phase);
    if (item_i.start_req) begin
      phase_d = PH_COARSE;
    end else begin
      unique case (phase_e'(state_i.phase))
        PH_COARSE:  if (sw_a) phase_d = PH_BACKOFF;
        PH_BACKOFF: if (hit_a) phase_d = PH_FINE;
        PH_FINE:    if (sw_a) phase_d = PH_A_FAR;
        PH_A_FAR:   if (hit_a) phase_d = PH_B_PLACE;
        PH_B_PLACE: if (hit_b) phase_d = PH_RISE;
        PH_RISE:    if (sw_b) phase_d = PH_FALL;
        PH_FALL:    if (!sw_b) phase_d = PH_ZERO;
        PH_ZERO:    if (hit_a && hit_b) phase_d = PH_DONE;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_i;
    lda     = 1'b0;
    ldb     = 1'b0;
    enca    = '0;
    encb    = '0;
    if (item_i.start_req) begin
      state_d.rise_pos = '0;
      state_d.vel_a    = cfg_i.coarse_speed;
      state_d.tgt_a    = '0;
      state_d.vel_b    = '0;
      state_d.tgt_b    = cfg_i.b_start;
    end else begin
      case (phase_e'(state_i.phase))
        PH_COARSE: begin
          if (sw_a) begin
            state_d.vel_a = '0;
            state_d.tgt_a = back_tgt;
          end
        end
        PH_BACKOFF: begin
          if (hit_a) state_d.vel_a = cfg_i.fine_speed;
        end
        PH_FINE: begin
          if (sw_a) begin
            state_d.vel_a = '0;
            lda           = 1'b1;
            enca          = cfg_i.a_end;
            state_d.tgt_a = cfg_i.a_far;
          end
        end
        PH_B_PLACE: begin
          if (hit_b) state_d.vel_b = neg_fine;
        end
        PH_RISE: begin
          if (sw_b) state_d.rise_pos = pb;
        end
        PH_FALL: begin
          if (!sw_b) begin
            state_d.vel_b = '0;
            ldb           = 1'b1;
            encb          = cal_pos;
            state_d.tgt_a = '0;
            state_d.tgt_b = '0;
          end
        end
        default: ;
      endcase
    end
    state_d.phase = phase_d;
  end

  always_comb begin
    state_o            = state_d;
    res_o.vel_a_cmd    = state_d.vel_a;
    res_o.pos_a_target = state_d.tgt_a;
    res_o.vel_b_cmd    = state_d.vel_b;
    res_o.pos_b_target = state_d.tgt_b;
    res_o.load_enc_a   = lda;
    res_o.enc_a_value  = enca;
    res_o.load_enc_b   = ldb;
    res_o.enc_b_value  = encb;
    res_o.phase        = phase_d;
    res_o.done_res     = (phase_d == PH_DONE);
  end

endmodule
`default_nettype wire

/* rtl/core/two_axis_homing_sequencer_top.sv */
// Two-axis homing sequencer.
// in_i carries one control tick: start request, both raw endstop levels and
// both measured positions. res_o returns one result per tick: velocity and
// position commands of both axes, one-tick encoder reload strobes with their
// values, the current phase and the done flag.
// Settings are written through the APB port (one register per word); write
// them only while no tick is in flight.
// Each tick passes through the input register, one pass of sequencing logic
// and the result register.
// Throughput: one tick per cycle while res_o does not stall.
// When res_o stalls, the result register holds and the input register takes
// one more tick; in_i.ready then drops until res_o moves again.
// Reset clears the phase to idle, the held velocities and targets to zero and
// the settings to their defaults; no clearing pass is needed.
`default_nettype none
module two_axis_homing_sequencer_top #(
  parameter int unsigned POS_WIDTH = tahs_pkg::POS_WIDTH_DEF,
  localparam int unsigned DATA_W   = (POS_WIDTH > 32) ? 64 : 32,
  localparam int unsigned ADDR_LSB = (POS_WIDTH > 32) ? 3 : 2,
  localparam int unsigned ADDR_W   = ADDR_LSB + tahs_pkg::REG_IDX_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tahs_in_if.sink                in_i,
  tahs_res_if.source             res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);
  import tahs_pkg::*;

  typedef logic signed [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    logic [TOL_W-1:0] tol;
    pos_t             coarse_speed;
    pos_t             fine_speed;
    pos_t             a_end;
    pos_t             a_far;
    pos_t             b_end;
    pos_t             b_start;
    logic [TOL_W-1:0] backoff;
  } cfg_t;

  typedef struct packed {
    phase_e phase;
    pos_t   rise_pos;
    pos_t   vel_a;
    pos_t   tgt_a;
    pos_t   vel_b;
    pos_t   tgt_b;
  } state_t;

  typedef struct packed {
    logic start_req;
    logic endstop_a_level;
    logic endstop_b_level;
    pos_t pos_a;
    pos_t pos_b;
  } item_t;

  typedef struct packed {
    pos_t   vel_a_cmd;
    pos_t   pos_a_target;
    pos_t   vel_b_cmd;
    pos_t   pos_b_target;
    logic   load_enc_a;
    pos_t   enc_a_value;
    logic   load_enc_b;
    pos_t   enc_b_value;
    phase_e phase;
    logic   done_res;
  } res_t;

  cfg_t   cfg;
  state_t state_q, state_d;
  item_t  item_q;
  res_t   res_q, res_d;
  logic   s1_valid_q;
  logic   out_valid_q;
  logic   adv_out;
  logic   in_xfer;

  tahs_cfg_regs #(
    .POS_WIDTH (POS_WIDTH),
    .cfg_t     (cfg_t)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tahs_step #(
    .POS_WIDTH (POS_WIDTH),
    .cfg_t     (cfg_t),
    .state_t   (state_t),
    .item_t    (item_t),
    .res_t     (res_t)
  ) u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign adv_out    = !out_valid_q || res_o.ready;
  assign in_i.ready = !s1_valid_q || adv_out;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (adv_out) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.start_req       <= in_i.start_req;
      item_q.endstop_a_level <= in_i.endstop_a_level;
      item_q.endstop_b_level <= in_i.endstop_b_level;
      item_q.pos_a           <= in_i.pos_a;
      item_q.pos_b           <= in_i.pos_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, default: '0};
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && adv_out) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && adv_out) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.vel_a_cmd    = res_q.vel_a_cmd;
  assign res_o.pos_a_target = res_q.pos_a_target;
  assign res_o.vel_b_cmd    = res_q.vel_b_cmd;
  assign res_o.pos_b_target = res_q.pos_b_target;
  assign res_o.load_enc_a   = res_q.load_enc_a;
  assign res_o.enc_a_value  = res_q.enc_a_value;
  assign res_o.load_enc_b   = res_q.load_enc_b;
  assign res_o.enc_b_value  = res_q.enc_b_value;
  assign res_o.phase        = res_q.phase;
  assign res_o.done_res     = res_q.done_res;

  a_lda_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.load_enc_a |-> res_o.phase == PH_A_FAR)
    else $error("encoder A reload outside the far-move entry");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.done_res == (res_o.phase == PH_DONE))
    else $error("done flag disagrees with phase");

  a_encb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.load_enc_b |-> res_o.enc_b_value == '0)
    else $error("encoder B value set without reload");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && adv_out) |=> $stable(state_q))
    else $error("sequencer state moved without a tick");

endmodule
`default_nettype wire

/* tb/two_axis_homing_sequencer_top_tb.sv */
`timescale 1ns / 100ps

module two_axis_homing_sequencer_top_tb;
  import tahs_pkg::*;

  localparam int unsigned W = POS_WIDTH_DEF;
  localparam longint PMAX = (longint'(1) << (W - 1)) - 1;
  localparam longint PMIN = -PMAX - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 50;

  typedef logic signed [W-1:0] pos_t;

  localparam pos_t POS_MAX = pos_t'(PMAX);
  localparam pos_t POS_MIN = pos_t'(PMIN);

  typedef struct packed {
    logic start;
    logic lvl_a;
    logic lvl_b;
    pos_t pos_a;
    pos_t pos_b;
  } tick_t;

  typedef struct packed {
    pos_t   vel_a;
    pos_t   tgt_a;
    pos_t   vel_b;
    pos_t   tgt_b;
    logic   load_a;
    pos_t   enc_a;
    logic   load_b;
    pos_t   enc_b;
    phase_e phase;
    logic   done;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tahs_in_if  #(.POS_WIDTH(W)) in_if ();
  tahs_res_if #(.POS_WIDTH(W)) res_if ();

  two_axis_homing_sequencer_top #(.POS_WIDTH(W)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [30:0] tol_cfg, backoff_cfg;
  pos_t coarse_cfg, fine_cfg, a_end_cfg, a_far_cfg, b_end_cfg, b_start_cfg;

  phase_e ph;
  pos_t   rise_pos, vel_a, tgt_a, vel_b, tgt_b;

  tick_t pending_ticks[$];
  cmd_t  expected_cmds[$];

  int  errors = 0;
  int  cycles = 0;
  int  queued = 0;
  int  ticks_sent = 0;
  int  results_seen = 0;
  int  a_reloads = 0;
  int  b_reloads = 0;
  int  done_runs = 0;
  int  setting_count = 0;
  bit  steady = 1'b0;

  task automatic flag_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  function automatic pos_t clamp_pos(longint v);
    if (v > PMAX) return POS_MAX;
    if (v < PMIN) return POS_MIN;
    return pos_t'(v);
  endfunction

  function automatic bit within_tol(pos_t p, pos_t tgt);
    longint d;
    d = longint'(p) - longint'(tgt);
    if (d < 0) d = -d;
    return d < longint'(tol_cfg);
  endfunction

  function automatic cmd_t advance_homing(tick_t t);
    cmd_t c;
    c = '0;
    if (t.start) begin
      rise_pos = '0;
      vel_a    = coarse_cfg;
      tgt_a    = '0;
      vel_b    = '0;
      tgt_b    = b_start_cfg;
      ph       = PH_COARSE;
    end else begin
      case (ph)
        PH_COARSE: if (t.lvl_a) begin
          vel_a = '0;
          tgt_a = clamp_pos(longint'(t.pos_a) - longint'(backoff_cfg));
          ph    = PH_BACKOFF;
        end
        PH_BACKOFF: if (within_tol(t.pos_a, tgt_a)) begin
          vel_a = fine_cfg;
          ph    = PH_FINE;
        end
        PH_FINE: if (t.lvl_a) begin
          vel_a    = '0;
          c.load_a = 1'b1;
          c.enc_a  = a_end_cfg;
          tgt_a    = a_far_cfg;
          ph       = PH_A_FAR;
        end
        PH_A_FAR: if (within_tol(t.pos_a, tgt_a)) ph = PH_B_PLACE;
        PH_B_PLACE: if (within_tol(t.pos_b, tgt_b)) begin
          vel_b = clamp_pos(-longint'(fine_cfg));
          ph    = PH_RISE;
        end
        PH_RISE: if (!t.lvl_b) begin
          rise_pos = t.pos_b;
          ph       = PH_FALL;
        end
        PH_FALL: if (t.lvl_b) begin
          vel_b    = '0;
          c.load_b = 1'b1;
          c.enc_b  = clamp_pos(longint'(b_end_cfg) +
                               ((longint'(t.pos_b) - longint'(rise_pos)) >>> 1));
          tgt_a    = '0;
          tgt_b    = '0;
          ph       = PH_ZERO;
        end
        PH_ZERO: if (within_tol(t.pos_a, tgt_a) && within_tol(t.pos_b, tgt_b)) ph = PH_DONE;
        default: ;
      endcase
    end
    c.vel_a = vel_a;
    c.tgt_a = tgt_a;
    c.vel_b = vel_b;
    c.tgt_b = tgt_b;
    c.phase = ph;
    c.done  = (ph == PH_DONE);
    return c;
  endfunction

  always @(posedge clk) begin : drive_ticks
    tick_t sent, nxt;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sent.start = in_if.start_req;
        sent.lvl_a = in_if.endstop_a_level;
        sent.lvl_b = in_if.endstop_b_level;
        sent.pos_a = in_if.pos_a;
        sent.pos_b = in_if.pos_b;
        expected_cmds.push_back(advance_homing(sent));
        ticks_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_ticks.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
          nxt = pending_ticks.pop_front();
          in_if.valid           <= 1'b1;
          in_if.start_req       <= nxt.start;
          in_if.endstop_a_level <= nxt.lvl_a;
          in_if.endstop_b_level <= nxt.lvl_b;
          in_if.pos_a           <= nxt.pos_a;
          in_if.pos_b           <= nxt.pos_b;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    cmd_t got, want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        got.vel_a  = res_if.vel_a_cmd;
        got.tgt_a  = res_if.pos_a_target;
        got.vel_b  = res_if.vel_b_cmd;
        got.tgt_b  = res_if.pos_b_target;
        got.load_a = res_if.load_enc_a;
        got.enc_a  = res_if.enc_a_value;
        got.load_b = res_if.load_enc_b;
        got.enc_b  = res_if.enc_b_value;
        got.phase  = phase_e'(res_if.phase);
        got.done   = res_if.done_res;
        if (expected_cmds.size() == 0) begin
          flag_mismatch("result with nothing pending, phase", longint'(got.phase), -1);
        end else begin
          want = expected_cmds.pop_front();
          if (got.vel_a !== want.vel_a) flag_mismatch("vel_a_cmd", got.vel_a, want.vel_a);
          if (got.tgt_a !== want.tgt_a) flag_mismatch("pos_a_target", got.tgt_a, want.tgt_a);
          if (got.vel_b !== want.vel_b) flag_mismatch("vel_b_cmd", got.vel_b, want.vel_b);
          if (got.tgt_b !== want.tgt_b) flag_mismatch("pos_b_target", got.tgt_b, want.tgt_b);
          if (got.load_a !== want.load_a) flag_mismatch("load_enc_a", got.load_a, want.load_a);
          if (got.enc_a !== want.enc_a) flag_mismatch("enc_a_value", got.enc_a, want.enc_a);
          if (got.load_b !== want.load_b) flag_mismatch("load_enc_b", got.load_b, want.load_b);
          if (got.enc_b !== want.enc_b) flag_mismatch("enc_b_value", got.enc_b, want.enc_b);
          if (got.phase !== want.phase)
            flag_mismatch("phase", longint'(got.phase), longint'(want.phase));
          if (got.done !== want.done) flag_mismatch("done_res", got.done, want.done);
          if (want.load_a) a_reloads++;
          if (want.load_b) b_reloads++;
          if (want.done) done_runs++;
        end
      end
      res_if.ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               expected_cmds.size());
      $display("two_axis_homing_sequencer_top regression: fail");
      $finish;
    end
  end

  task automatic write_setting(reg_idx_e idx, logic [31:0] value);
    bit ok;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TOL:     tol_cfg     = value[30:0];
      REG_COARSE:  coarse_cfg  = pos_t'(value);
      REG_FINE:    fine_cfg    = pos_t'(value);
      REG_A_END:   a_end_cfg   = pos_t'(value);
      REG_A_FAR:   a_far_cfg   = pos_t'(value);
      REG_B_END:   b_end_cfg   = pos_t'(value);
      REG_B_START: b_start_cfg = pos_t'(value);
      REG_BACKOFF: backoff_cfg = value[30:0];
      default: ;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_TOL || idx == REG_BACKOFF)
      ok = (prdata[30:0] === value[30:0]);
    else
      ok = (prdata === value);
    if (!ok) flag_mismatch("register readback", prdata, value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_settings(logic [31:0] tol, logic [31:0] coarse, logic [31:0] fine,
                                  logic [31:0] a_end, logic [31:0] a_far, logic [31:0] b_end,
                                  logic [31:0] b_start, logic [31:0] backoff);
    write_setting(REG_TOL, tol);
    write_setting(REG_COARSE, coarse);
    write_setting(REG_FINE, fine);
    write_setting(REG_A_END, a_end);
    write_setting(REG_A_FAR, a_far);
    write_setting(REG_B_END, b_end);
    write_setting(REG_B_START, b_start);
    write_setting(REG_BACKOFF, backoff);
    setting_count++;
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_if.valid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_tick(bit s, bit la, bit lb, pos_t pa, pos_t pb);
    tick_t t;
    t.start = s;
    t.lvl_a = la;
    t.lvl_b = lb;
    t.pos_a = pa;
    t.pos_b = pb;
    pending_ticks.push_back(t);
    queued++;
  endtask

  function automatic bit coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic pos_t any_pos();
    case ($urandom_range(7))
      0:       return POS_MIN;
      1:       return POS_MAX;
      2:       return clamp_pos(longint'($urandom_range(2000)) - 1000);
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic pos_t near(pos_t tgt);
    longint span, off;
    if (tol_cfg == '0) return any_pos();
    span = longint'(tol_cfg) - 1;
    case ($urandom_range(3))
      0:       off = span;
      1:       off = -span;
      default: off = longint'($urandom_range(32'(2 * span))) - span;
    endcase
    return clamp_pos(longint'(tgt) + off);
  endfunction

  function automatic pos_t miss(pos_t tgt);
    if (coin())
      return clamp_pos(longint'(tgt) + (coin() ? longint'(tol_cfg) : -longint'(tol_cfg)));
    return any_pos();
  endfunction

  task automatic queue_homing_run();
    int   stop_at, n;
    bit   adv;
    pos_t pa, hit_a, back_tgt;
    hit_a    = '0;
    back_tgt = '0;
    stop_at  = ($urandom_range(4) == 0) ? $urandom_range(1, 8) : 9;
    queue_tick(1'b1, coin(), coin(), any_pos(), any_pos());
    for (int st = 1; st <= stop_at; st++) begin
      n = $urandom_range(3);
      for (int k = 0; k <= n; k++) begin
        adv = (k == n) && (st < stop_at);
        case (st)
          1: begin
            pa = any_pos();
            if (adv) hit_a = pa;
            queue_tick(1'b0, adv, coin(), pa, any_pos());
          end
          2: queue_tick(1'b0, coin(), coin(), adv ? near(back_tgt) : miss(back_tgt), any_pos());
          3: queue_tick(1'b0, adv, coin(), any_pos(), any_pos());
          4: queue_tick(1'b0, coin(), coin(), adv ? near(a_far_cfg) : miss(a_far_cfg),
                        any_pos());
          5: queue_tick(1'b0, coin(), coin(), any_pos(),
                        adv ? near(b_start_cfg) : miss(b_start_cfg));
          6: queue_tick(1'b0, coin(), !adv, any_pos(), any_pos());
          7: queue_tick(1'b0, coin(), adv, any_pos(), any_pos());
          8: begin
            if (adv) queue_tick(1'b0, coin(), coin(), near('0), near('0));
            else queue_tick(1'b0, coin(), coin(), miss('0), coin() ? near('0) : miss('0));
          end
          default: queue_tick(1'b0, coin(), coin(), any_pos(), any_pos());
        endcase
      end
      if (st == 1) back_tgt = clamp_pos(longint'(hit_a) - longint'(backoff_cfg));
    end
  endtask

  task automatic queue_random(int count);
    int goal;
    goal = queued + count;
    while (queued < goal) begin
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 3))
          queue_tick($urandom_range(7) == 0, coin(), coin(), any_pos(), any_pos());
      else
        queue_homing_run();
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.start_req       = 1'b0;
    in_if.endstop_a_level = 1'b0;
    in_if.endstop_b_level = 1'b1;
    in_if.pos_a           = '0;
    in_if.pos_b           = '0;
    res_if.ready          = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    tol_cfg     = RST_TOL[30:0];
    coarse_cfg  = pos_t'(RST_COARSE);
    fine_cfg    = pos_t'(RST_FINE);
    a_end_cfg   = pos_t'(RST_A_END);
    a_far_cfg   = pos_t'(RST_A_FAR);
    b_end_cfg   = pos_t'(RST_B_END);
    b_start_cfg = pos_t'(RST_B_START);
    backoff_cfg = RST_BACKOFF[30:0];
    ph       = PH_IDLE;
    rise_pos = '0;
    vel_a    = '0;
    tgt_a    = '0;
    vel_b    = '0;
    tgt_b    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    queue_tick(1'b0, 1'b1, 1'b0, POS_MAX, POS_MIN);
    queue_tick(1'b0, 1'b0, 1'b1, POS_MIN, POS_MAX);
    queue_tick(1'b1, 1'b1, 1'b0, '0, '0);
    queue_tick(1'b0, 1'b0, 1'b1, -5, 7);
    queue_tick(1'b0, 1'b1, 1'b1, POS_MIN, '0);
    queue_tick(1'b0, 1'b0, 1'b1, clamp_pos(PMIN + 655), '0);
    queue_tick(1'b0, 1'b0, 1'b1, clamp_pos(PMIN + 654), '0);
    queue_tick(1'b0, 1'b0, 1'b0, '0, '0);
    queue_tick(1'b0, 1'b1, 1'b0, '0, '0);
    queue_tick(1'b0, 1'b0, 1'b1, 196608 - 655, '0);
    queue_tick(1'b0, 1'b1, 1'b0, 196608 + 654, '0);
    queue_tick(1'b0, 1'b0, 1'b1, '0, 98304 - 654);
    queue_tick(1'b0, 1'b0, 1'b1, '0, '0);
    queue_tick(1'b0, 1'b0, 1'b0, '0, POS_MAX);
    queue_tick(1'b0, 1'b1, 1'b0, '0, '0);
    queue_tick(1'b0, 1'b0, 1'b1, '0, POS_MIN);
    queue_tick(1'b0, 1'b0, 1'b0, '0, 655);
    queue_tick(1'b0, 1'b0, 1'b0, -654, -654);
    queue_tick(1'b0, 1'b1, 1'b0, POS_MAX, POS_MIN);
    queue_tick(1'b1, 1'b0, 1'b0, '0, '0);
    queue_tick(1'b0, 1'b1, 1'b1, POS_MAX, '0);
    queue_tick(1'b1, 1'b0, 1'b1, '0, '0);
    queue_tick(1'b0, 1'b0, 1'b1, '0, '0);
    queue_random(200);
    drain();

    program_settings(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    queue_tick(1'b1, 1'b0, 1'b1, '0, '0);
    queue_tick(1'b0, 1'b1, 1'b1, POS_MIN, '0);
    queue_tick(1'b0, 1'b0, 1'b1, POS_MIN, '0);
    queue_tick(1'b0, 1'b1, 1'b1, '0, '0);
    queue_tick(1'b0, 1'b0, 1'b1, POS_MIN, '0);
    queue_tick(1'b0, 1'b0, 1'b1, '0, POS_MIN);
    queue_tick(1'b0, 1'b0, 1'b0, '0, POS_MIN);
    queue_tick(1'b0, 1'b0, 1'b1, '0, POS_MAX);
    queue_tick(1'b0, 1'b0, 1'b1, '0, '0);
    queue_tick(1'b0, 1'b1, 1'b0, '0, '0);
    queue_random(90);
    drain();

    program_settings(32'd0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
    queue_random(60);
    drain();

    steady = 1'b1;
    program_settings(32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
    queue_random(120);
    drain();
    steady = 1'b0;

    repeat (3) begin
      program_settings(($urandom_range(2) == 0) ? ($urandom & 32'h7fff_ffff)
                                                : $urandom_range(1, 300000),
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       coin() ? $urandom_range(500000) : $urandom);
      queue_random(100);
      drain();
    end

    $display("sent %0d control ticks, checked %0d results across %0d register settings",
             ticks_sent, results_seen, setting_count);
    $display("axis A reloads %0d, axis B reloads %0d, done results %0d, mismatches %0d",
             a_reloads, b_reloads, done_runs, errors);
    if (errors == 0) begin
      $display("two_axis_homing_sequencer_top regression: pass");
    end else begin
      $display("two_axis_homing_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tahs_pkg.sv
rtl/core/tahs_if.sv
rtl/core/tahs_cfg_regs.sv
rtl/core/tahs_step.sv
rtl/core/two_axis_homing_sequencer_top.sv
tb/two_axis_homing_sequencer_top_tb.sv
